FILE: hdl/adsl_pkg.sv
// Shared types and constants for the audio DC shift limiter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package adsl_pkg;

	// Sample and derived widths
	localparam int SAMPLE_BITS = 16;
	localparam int GAIN_BITS   = SAMPLE_BITS - 1;
	localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
	localparam int RES_BITS    = PROD_BITS + 2;
	localparam int SUM_BITS    = RES_BITS + 1;

	// Configuration register indexes
	localparam int IDX_BITS = 2;
	localparam logic [IDX_BITS-1:0] REG_DC_OFFSET    = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_LIMITER_GAIN = IDX_BITS'(1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [GAIN_BITS-1:0]          gain_t;

	// Full scale and clip limits
	localparam gain_t   FULL_SCALE = {GAIN_BITS{1'b1}};
	localparam sample_t SMP_MAX    = {1'b0, {GAIN_BITS{1'b1}}};
	localparam sample_t SMP_MIN    = {1'b1, {GAIN_BITS{1'b0}}};

	// Per-sample data that rides along with the divider
	typedef struct packed {
		sample_t smp;
		gain_t   thr;
		logic    neg;
		logic    comp;
	} side_t;

endpackage

FILE: hdl/adsl_if.sv
// Handshake channels of the audio DC shift limiter: sample in, sample out, config.
// Depends on adsl_pkg.
`timescale 1ns / 1ps

interface adsl_in_if import adsl_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t in_sample;

	modport source(output valid, output in_sample, input ready);
	modport sink(input valid, input in_sample, output ready);
endinterface

interface adsl_out_if import adsl_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t out_sample;

	modport source(output valid, output out_sample, input ready);
	modport sink(input valid, input out_sample, output ready);
endinterface

interface adsl_cfg_if import adsl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [IDX_BITS-1:0]    index;
	logic [SAMPLE_BITS-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/audio_dc_shift_limiter.sv
// Audio DC shift with peak limiter: top level, config registers and pipeline.
// Pipeline: 3 front stages, 31 divider stages and 2 back stages between an
// accepted word and its result word. Throughput: one word per cycle, set by
// the fully pipelined bit-per-stage divider; a stall freezes the whole pipe.
// Reset clears all valid bits and sets dc_offset and limiter_gain to zero.
// Depends on adsl_pkg, adsl_if and adsl_div.
`timescale 1ns / 1ps

module audio_dc_shift_limiter import adsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	adsl_in_if.sink    sample_ch,
	adsl_out_if.source result_ch,
	adsl_cfg_if.sink   cfg
);

	sample_t dc_offset_q;
	gain_t   limiter_gain_q;
	logic    adv;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_offset_q    <= '0;
			limiter_gain_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DC_OFFSET:    dc_offset_q    <= cfg.data;
				REG_LIMITER_GAIN: limiter_gain_q <= cfg.data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Whole pipe moves when the output register is free or being taken
	logic    vld_s5;
	sample_t res_s5;

	assign adv             = !vld_s5 || result_ch.ready;
	assign sample_ch.ready = adv;

	// Stage 1: threshold = max(gain - |offset|, 0)
	logic signed [SAMPLE_BITS:0]   off_ext;
	logic        [SAMPLE_BITS:0]   mag;
	logic signed [SAMPLE_BITS+1:0] diff;
	gain_t                         thr0;
	logic                          vld_s1;
	sample_t                       smp_s1;
	gain_t                         thr_s1;

	always_comb begin
		off_ext = (SAMPLE_BITS + 1)'(dc_offset_q);
		mag     = off_ext[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-off_ext)
		                               : (SAMPLE_BITS + 1)'(off_ext);
		diff    = $signed({3'b000, limiter_gain_q}) - $signed({1'b0, mag});
		thr0    = diff[SAMPLE_BITS+1] ? '0 : diff[GAIN_BITS-1:0];
	end

	// Stage 2: divisor, side decision and excess magnitude
	gain_t                         den1;
	logic                          pos1;
	logic                          neg1;
	logic                          comp1;
	logic signed [SAMPLE_BITS+1:0] smp_ext1;
	logic signed [SAMPLE_BITS+1:0] thr_ext1;
	logic signed [SAMPLE_BITS+1:0] exc1;
	logic                          vld_s2;
	sample_t                       smp_s2;
	gain_t                         thr_s2;
	gain_t                         den_s2;
	logic                          neg_s2;
	logic                          comp_s2;
	logic [SAMPLE_BITS-1:0]        m_s2;

	always_comb begin
		den1     = FULL_SCALE - thr_s1;
		neg1     = dc_offset_q[SAMPLE_BITS-1];
		pos1     = !neg1 && (dc_offset_q != '0);
		smp_ext1 = (SAMPLE_BITS + 2)'(smp_s1);
		thr_ext1 = $signed({3'b000, thr_s1});
		comp1    = (limiter_gain_q != '0) && (den1 != '0) &&
		           ((pos1 && (smp_ext1 > thr_ext1)) || (neg1 && (smp_ext1 < -thr_ext1)));
		exc1     = neg1 ? (-smp_ext1 - thr_ext1) : (smp_ext1 - thr_ext1);
	end

	// Stage 3: excess times gain
	logic                 vld_s3;
	logic [PROD_BITS-1:0] prod_s3;
	gain_t                den_s3;
	side_t                side_s3;

	// Front pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample_ch.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Front pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s1  <= sample_ch.in_sample;
			thr_s1  <= thr0;
			smp_s2  <= smp_s1;
			thr_s2  <= thr_s1;
			den_s2  <= den1;
			neg_s2  <= neg1;
			comp_s2 <= comp1;
			m_s2    <= exc1[SAMPLE_BITS-1:0];
			prod_s3 <= PROD_BITS'(m_s2) * PROD_BITS'(limiter_gain_q);
			den_s3  <= den_s2;
			side_s3 <= '{smp: smp_s2, thr: thr_s2, neg: neg_s2, comp: comp_s2};
		end
	end

	// Divide the scaled excess by (full scale - threshold)
	logic                 vld_d;
	logic [PROD_BITS-1:0] quo_d;
	side_t                side_d;

	adsl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.start_vld (vld_s3),
		.dividend  (prod_s3),
		.divisor   (den_s3),
		.side      (side_s3),
		.done_vld  (vld_d),
		.quotient  (quo_d),
		.side_done (side_d)
	);

	// Stage 4: add threshold back and restore the sign; uncompressed words pass through
	logic        [PROD_BITS:0]  magr;
	logic signed [RES_BITS-1:0] lim4;
	logic                       vld_s4;
	logic signed [RES_BITS-1:0] r_s4;

	always_comb begin
		magr = (PROD_BITS + 1)'(quo_d) + (PROD_BITS + 1)'(side_d.thr);
		if (!side_d.comp) begin
			lim4 = RES_BITS'(side_d.smp);
		end else if (side_d.neg) begin
			lim4 = -$signed({1'b0, magr});
		end else begin
			lim4 = $signed({1'b0, magr});
		end
	end

	// Stage 5: add offset and clip to the sample range
	logic signed [SUM_BITS-1:0] sum5;
	sample_t                    clip5;

	always_comb begin
		sum5 = SUM_BITS'(r_s4) + SUM_BITS'(dc_offset_q);
		if (sum5 > SUM_BITS'(SMP_MAX)) begin
			clip5 = SMP_MAX;
		end else if (sum5 < SUM_BITS'(SMP_MIN)) begin
			clip5 = SMP_MIN;
		end else begin
			clip5 = sum5[SAMPLE_BITS-1:0];
		end
	end

	// Back pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_d;
			vld_s5 <= vld_s4;
		end
	end

	// Back pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s4   <= lim4;
			res_s5 <= clip5;
		end
	end

	assign result_ch.valid      = vld_s5;
	assign result_ch.out_sample = res_s5;

	// The excess never exceeds the divisor (plus one on the negative side)
	a_excess_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && comp_s2 |->
		(neg_s2 ? ({1'b0, m_s2} <= {2'b00, den_s2} + 1'b1) : (m_s2 <= {1'b0, den_s2})))
		else $error("limiter excess larger than divisor");

	// Compressed quotient fits in the low SAMPLE_BITS bits
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_d && side_d.comp |-> (quo_d[PROD_BITS-1:SAMPLE_BITS] == '0))
		else $error("limiter quotient out of range");

	// A stall freezes the pipe
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s3) && $stable(prod_s3) && $stable(vld_d))
		else $error("pipeline moved during stall");

endmodule

FILE: hdl/adsl_div.sv
// Pipelined restoring divider: one quotient bit per stage, one word per cycle
// while adv is high. Carries a side_t word alongside; depends on adsl_pkg.
`timescale 1ns / 1ps

module adsl_div import adsl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 start_vld,
	input  logic [PROD_BITS-1:0] dividend,
	input  gain_t                divisor,
	input  side_t                side,
	output logic                 done_vld,
	output logic [PROD_BITS-1:0] quotient,
	output side_t                side_done
);

	logic                 vld_s  [1:PROD_BITS];
	gain_t                rem_s  [1:PROD_BITS];
	logic [PROD_BITS-1:0] dvd_s  [1:PROD_BITS];
	logic [PROD_BITS-1:0] quo_s  [1:PROD_BITS];
	gain_t                den_s  [1:PROD_BITS];
	side_t                side_s [1:PROD_BITS];

	for (genvar k = 1; k <= PROD_BITS; k++) begin : g_stage
		logic                 vld_p;
		gain_t                rem_p;
		logic [PROD_BITS-1:0] dvd_p;
		logic [PROD_BITS-1:0] quo_p;
		gain_t                den_p;
		side_t                side_p;
		logic [GAIN_BITS:0]   trial;
		logic                 fit;

		// Select the previous stage, or the inputs for the first one
		if (k == 1) begin : g_first
			assign vld_p  = start_vld;
			assign rem_p  = '0;
			assign dvd_p  = dividend;
			assign quo_p  = '0;
			assign den_p  = divisor;
			assign side_p = side;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign dvd_p  = dvd_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign den_p  = den_s[k-1];
			assign side_p = side_s[k-1];
		end

		// Bring down the next dividend bit and try the subtraction
		assign trial = {rem_p, dvd_p[PROD_BITS-1]};
		assign fit   = trial >= {1'b0, den_p};

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_p;
			end
		end

		// Advance the partial remainder, quotient and side word
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= fit ? GAIN_BITS'(trial - {1'b0, den_p}) : trial[GAIN_BITS-1:0];
				dvd_s[k]  <= {dvd_p[PROD_BITS-2:0], 1'b0};
				quo_s[k]  <= {quo_p[PROD_BITS-2:0], fit};
				den_s[k]  <= den_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign done_vld  = vld_s[PROD_BITS];
	assign quotient  = quo_s[PROD_BITS];
	assign side_done = side_s[PROD_BITS];

endmodule

FILE: tb/sv/tb_audio_dc_shift_limiter.sv
// Self-checking testbench for audio_dc_shift_limiter: directed corner words, then
// randomized configuration phases with random stalls on both channels.
// Depends on adsl_pkg, adsl_if and the audio_dc_shift_limiter RTL.
`timescale 1ns / 1ps

module tb_audio_dc_shift_limiter import adsl_pkg::*; ();

	localparam int LATENCY     = 36;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_PHASE  = 2;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_PHASES = 10;

	// Expected-sample store with its own copy of the limiter settings
	class limiter_scoreboard;
		sample_t dc_off;
		gain_t   gain;
		sample_t pending[$];
		int      errors;
		int      n_in;
		int      n_out;

		function new();
			dc_off = '0;
			gain   = '0;
			errors = 0;
			n_in   = 0;
			n_out  = 0;
		endfunction

		function void report(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		endfunction

		function void set_reg(logic [IDX_BITS-1:0] idx, logic [SAMPLE_BITS-1:0] d);
			case (idx)
				REG_DC_OFFSET: begin
					dc_off = sample_t'(d);
				end
				REG_LIMITER_GAIN: begin
					gain = d[GAIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Compress peaks on the offset side, add the offset, clip
		function sample_t shift_and_limit(sample_t x);
			longint fs, v, off, g, mag, thr, den;
			fs  = longint'(FULL_SCALE);
			v   = x;
			off = dc_off;
			g   = longint'(gain);
			if (g > 0) begin
				mag = (off < 0) ? -off : off;
				thr = g - mag;
				if (thr < 0)
					thr = 0;
				den = fs - thr;
				if (den > 0) begin
					if (v > thr && off > 0)
						v = (v - thr) * g / den + thr;
					else if (v < -thr && off < 0)
						v = (v + thr) * g / den - thr;
				end
			end
			v = v + off;
			if (v > fs)
				v = fs;
			else if (v < -fs - 1)
				v = -fs - 1;
			return sample_t'(v);
		endfunction

		function void note_input(sample_t x);
			n_in++;
			pending.push_back(shift_and_limit(x));
		endfunction

		function void check_result(sample_t got);
			sample_t want;
			n_out++;
			if (pending.size() == 0) begin
				report($sformatf("result word %0d arrived with nothing expected", got));
			end else begin
				want = pending.pop_front();
				if (got !== want)
					report($sformatf("out_sample %0d, expected %0d (word %0d)",
						got, want, n_out));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	adsl_in_if  sample_if ();
	adsl_out_if result_if ();
	adsl_cfg_if cfg_if ();

	audio_dc_shift_limiter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_if),
		.result_ch (result_if),
		.cfg       (cfg_if)
	);

	limiter_scoreboard sb = new();
	int phase_no;
	bit calm;
	int n_cfg;
	int cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Cycle limit: give up if the run hangs
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run exceeded %0d cycles", CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Result side: check accepted words, stall at random, hold off once
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready)
				sb.check_result(result_if.out_sample);
			if (phase_no == HOLD_PHASE && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= calm || ($urandom_range(0, 99) >= 30);
			end
		end
	end

	// Drop valid for random cycles unless in the calm stretch
	task automatic idle_gap();
		while (!calm && $urandom_range(0, 99) < 30) begin
			sample_if.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_sample(input sample_t s);
		idle_gap();
		sample_if.valid     <= 1'b1;
		sample_if.in_sample <= s;
		do @(posedge clk); while (!sample_if.ready);
		sb.note_input(s);
	endtask

	task automatic send_list(input sample_t list[$]);
		foreach (list[i])
			send_sample(list[i]);
		sample_if.valid <= 1'b0;
	endtask

	// Wait until every expected word has come back
	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers back to back; call only while the block is idle
	task automatic write_cfg(input sample_t off, input gain_t g);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= REG_DC_OFFSET;
		cfg_if.data  <= off;
		do @(posedge clk); while (!cfg_if.ready);
		sb.set_reg(REG_DC_OFFSET, off);
		cfg_if.index <= REG_LIMITER_GAIN;
		cfg_if.data  <= {1'b0, g};
		do @(posedge clk); while (!cfg_if.ready);
		sb.set_reg(REG_LIMITER_GAIN, {1'b0, g});
		cfg_if.valid <= 1'b0;
		n_cfg += 2;
	endtask

	function automatic sample_t pick_offset();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SMP_MIN;
			2: return SMP_MAX;
			3: return sample_t'(-32767);
			4: return sample_t'(int'($urandom_range(0, 400)) - 200);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic gain_t pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return FULL_SCALE;
			2: return gain_t'(1);
			default: return gain_t'($urandom);
		endcase
	endfunction

	// Mostly full-range words, some extremes, some right around the knee
	function automatic sample_t pick_sample(sample_t off, gain_t g);
		longint mag, thr, v;
		int     k;
		k   = $urandom_range(0, 9);
		mag = off;
		if (mag < 0)
			mag = -mag;
		thr = longint'(g) - mag;
		if (thr < 0)
			thr = 0;
		if (k <= 5)
			return sample_t'($urandom);
		if (k == 6)
			return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
		v = thr + int'($urandom_range(0, 6)) - 3;
		if (k == 8)
			v = -v;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return sample_t'(v);
	endfunction

	// Stimulus
	initial begin
		int      n_items;
		sample_t off;
		gain_t   g;
		phase_no = 0;
		calm     = 1'b0;
		n_cfg    = 0;
		arst_n   = 1'b0;
		sample_if.valid     <= 1'b0;
		sample_if.in_sample <= '0;
		cfg_if.valid        <= 1'b0;
		cfg_if.index        <= REG_DC_OFFSET;
		cfg_if.data         <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: zero offset, limiter off, plain pass-through
		send_list('{SMP_MIN, SMP_MAX, 16'sd0, -16'sd1, 16'sd1});
		drain();
		// Shift only, clipping at the upper rail
		write_cfg(16'sd1000, '0);
		send_list('{SMP_MAX, SMP_MIN, 16'sd5});
		drain();
		// Most negative offset: threshold collapses to zero
		write_cfg(SMP_MIN, 15'd20000);
		send_list('{SMP_MAX, SMP_MIN, 16'sd0, -16'sd5});
		drain();
		// Largest offset and gain
		write_cfg(SMP_MAX, FULL_SCALE);
		send_list('{SMP_MAX, SMP_MIN, 16'sd1});
		drain();
		// Zero offset with full gain: divisor would be zero, nothing compressed
		write_cfg('0, FULL_SCALE);
		send_list('{SMP_MAX, SMP_MIN});
		drain();
		// Knee on the positive side, then mirrored on the negative side
		write_cfg(16'sd5000, 15'd16000);
		send_list('{16'sd11000, 16'sd11001, SMP_MAX, SMP_MIN, -16'sd11001});
		drain();
		write_cfg(-16'sd5000, 15'd16000);
		send_list('{-16'sd11000, -16'sd11001, SMP_MIN, SMP_MAX});
		drain();

		// Random phases, each with its own settings
		for (int p = 1; p <= RAND_PHASES; p++) begin
			phase_no = p;
			calm     = (p == 5 || p == 6);
			off      = pick_offset();
			g        = pick_gain();
			write_cfg(off, g);
			n_items = (p == HOLD_PHASE) ? 80 : $urandom_range(35, 60);
			for (int i = 0; i < n_items; i++)
				send_sample(pick_sample(off, g));
			sample_if.valid <= 1'b0;
			drain();
		end
		calm = 1'b0;

		// Let the pipe settle, then look for stray or missing words
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d expected words never arrived", sb.pending.size()));
		$display("Covered %0d words in, %0d out, %0d register writes, %0d random phases",
			sb.n_in, sb.n_out, n_cfg, RAND_PHASES);
		$display("Included rail offsets, zero and full gain, knee words and a %0d-cycle stall",
			HOLD_CYCLES);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/adsl_pkg.sv
hdl/adsl_if.sv
hdl/adsl_div.sv
hdl/audio_dc_shift_limiter.sv
tb/sv/tb_audio_dc_shift_limiter.sv
